/* hw/rtl/hit_time_walk_calibration_unit_defines.svh */
// assertion helpers for the hit calibration unit
`ifndef HIT_TIME_WALK_CALIBRATION_UNIT_DEFINES_SVH
`define HIT_TIME_WALK_CALIBRATION_UNIT_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define HTWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/htwc_pkg.sv */
`timescale 1ns / 1ps

package htwc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GLOBAL_OFFSET  = 2'd0;
    localparam logic [1:0] CFG_TDC_WIN_LOW    = 2'd1;
    localparam logic [1:0] CFG_TDC_WIN_HIGH   = 2'd2;
    localparam logic [1:0] CFG_WALK_THRESHOLD = 2'd3;

    localparam logic signed [31:0] RST_GLOBAL_OFFSET  = 32'sd0;
    localparam logic [11:0]        RST_TDC_WIN_LOW    = 12'd0;
    localparam logic [11:0]        RST_TDC_WIN_HIGH   = 12'd4095;
    localparam logic [12:0]        RST_WALK_THRESHOLD = 13'd50;

    // operation codes
    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // table selectors
    localparam logic [3:0] SEL_PEDESTAL     = 4'd0;
    localparam logic [3:0] SEL_PADDLE_DELAY = 4'd1;
    localparam logic [3:0] SEL_T0           = 4'd2;
    localparam logic [3:0] SEL_SLOPE        = 4'd3;
    localparam logic [3:0] SEL_ADC_MAX      = 4'd4;
    localparam logic [3:0] SEL_W0           = 4'd5;
    localparam logic [3:0] SEL_W1           = 4'd6;
    localparam logic [3:0] SEL_W2           = 4'd7;
    localparam logic [3:0] SEL_SECTOR_DELAY = 4'd8;

    localparam int NUM_CH_TABLES = 8;
    localparam int DIV_STEPS     = 48;
    localparam int T_W           = 46;
    localparam int D_W           = 35;
    localparam int SUM_W         = 51;

    localparam logic signed [47:0] HT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] HT_MIN = 48'sh8000_0000_0000;

    // one row holds all eight per-channel words, lane = table selector
    typedef logic [NUM_CH_TABLES-1:0][31:0] t_row;

    // everything that travels alongside the divider
    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic signed [31:0]    w0;
        logic                  use_walk;
        logic                  divz;
        logic                  w1_pos;
        logic                  w1_neg;
        logic                  q_neg;
        logic                  inwin;
        logic signed [31:0]    adc_sat;
        logic [9:0]            id;
    } t_ctx;

    typedef struct packed {
        logic                  divz;
        logic [9:0]            id;
        logic                  inwin;
        logic signed [47:0]    ht;
        logic signed [31:0]    adc;
    } t_result;

    function automatic logic signed [47:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [47:0] r;
        if (v > SUM_W'(HT_MAX)) begin
            r = HT_MAX;
        end else if (v < SUM_W'(HT_MIN)) begin
            r = HT_MIN;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/hit_time_walk_calibration_unit.sv */
// hit time-walk calibration: one transaction in per cycle when the output is not
// stalled, one result per hit on an in-range channel; a hit passes these
// registered steps: tables read at the accept edge, then adc/slope multiply,
// time sum, operand abs, 48-step divider, output register
// throughput: one item per cycle unless stalled (one-bit-per-stage divider)
// reset: synchronous active low; clears valids and config, tables stay undefined
`timescale 1ns / 1ps
`include "hit_time_walk_calibration_unit_defines.svh"

module hit_time_walk_calibration_unit #(
    parameter int NUM_SECTORS         = 6,
    parameter int SEGMENTS_PER_SECTOR = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel[4:0], raw_adc[17:5], tdc_count[29:18], cal_word[61:30], zero pad
    input  logic [63:0] s_axis_tdata,
    // op[0], table_sel[4:1]
    input  logic [4:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // adc_calibrated[31:0], hit_time[79:32], in_window[80], id_digits[90:81],
    // walk_div_zero[91], zero pad
    output logic [95:0] m_axis_tdata
);

    localparam int NUM_CH = NUM_SECTORS * SEGMENTS_PER_SECTOR;
    localparam int CH_AW  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int SEC_AW = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
    localparam int NS     = htwc_pkg::DIV_STEPS;
    localparam int T_W    = htwc_pkg::T_W;
    localparam int D_W    = htwc_pkg::D_W;
    localparam int SUM_W  = htwc_pkg::SUM_W;

    // field unpack
    logic              in_op;
    logic [4:0]        in_ch;
    logic [12:0]       in_raw;
    logic [11:0]       in_tdc;
    logic [3:0]        in_sel;
    logic [31:0]       in_word;
    assign in_op   = s_axis_tuser[0];
    assign in_sel  = s_axis_tuser[4:1];
    assign in_ch   = s_axis_tdata[4:0];
    assign in_raw  = s_axis_tdata[17:5];
    assign in_tdc  = s_axis_tdata[29:18];
    assign in_word = s_axis_tdata[61:30];

    logic en, acc, ch_ok, sec_ok;
    logic [CH_AW-1:0]  ch_addr;
    logic [SEC_AW-1:0] sec_wr_addr, sec_rd_addr;
    logic [7:0]        sector_n, segment_n, sec_base;
    logic [9:0]        id_n;

    assign en     = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign ch_ok  = 8'(in_ch) < 8'(NUM_CH);
    assign sec_ok = 8'(in_ch) < 8'(NUM_SECTORS);
    assign ch_addr     = CH_AW'(in_ch);
    assign sec_wr_addr = SEC_AW'(in_ch);

    // sector and segment by compare against each sector's first channel
    always_comb begin
        sector_n = '0;
        sec_base = '0;
        for (int s = 1; s < 32; s++) begin
            if (8'(in_ch) >= 8'(s * SEGMENTS_PER_SECTOR)) begin
                sector_n = 8'(s);
                sec_base = 8'(s * SEGMENTS_PER_SECTOR);
            end
        end
        segment_n = 8'(in_ch) - sec_base;
    end

    assign sec_rd_addr = SEC_AW'(sector_n);
    assign id_n = 10'((16'(sector_n) + 16'd1) * 16'd100 + (16'(segment_n) + 16'd1) * 16'd10);

    // configuration
    logic signed [31:0] r_global_offset;
    logic [11:0]        r_win_low, r_win_high;
    logic [12:0]        r_walk_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_offset <= htwc_pkg::RST_GLOBAL_OFFSET;
            r_win_low       <= htwc_pkg::RST_TDC_WIN_LOW;
            r_win_high      <= htwc_pkg::RST_TDC_WIN_HIGH;
            r_walk_thr      <= htwc_pkg::RST_WALK_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                htwc_pkg::CFG_GLOBAL_OFFSET:  r_global_offset <= i_cfg_wdata;
                htwc_pkg::CFG_TDC_WIN_LOW:    r_win_low       <= i_cfg_wdata[11:0];
                htwc_pkg::CFG_TDC_WIN_HIGH:   r_win_high      <= i_cfg_wdata[11:0];
                htwc_pkg::CFG_WALK_THRESHOLD: r_walk_thr      <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // calibration memories: writes happen on an accepted write, reads whenever
    // the pipeline advances, so a hit never overlaps a write to the same row
    htwc_pkg::t_row     r_chan_mem [NUM_CH];
    logic [31:0]        r_sec_mem  [NUM_SECTORS];
    htwc_pkg::t_row     r1_row;
    logic signed [31:0] r1_sd;

    always_ff @(posedge i_clk) begin
        if (acc && in_op == htwc_pkg::OP_WRITE) begin
            if (in_sel < htwc_pkg::SEL_SECTOR_DELAY && ch_ok) begin
                r_chan_mem[ch_addr][in_sel[2:0]] <= in_word;
            end
            if (in_sel == htwc_pkg::SEL_SECTOR_DELAY && sec_ok) begin
                r_sec_mem[sec_wr_addr] <= in_word;
            end
        end
        if (en) begin
            r1_row <= r_chan_mem[ch_addr];
            r1_sd  <= r_sec_mem[sec_rd_addr];
        end
    end

    // valid chain
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [NS-1:0] r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_dv <= '0;
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            r_v1 <= acc && in_op == htwc_pkg::OP_HIT && ch_ok;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_dv <= {r_dv[NS-2:0], r_v4};
            m_axis_tvalid <= r_dv[NS-1];
        end
    end

    // stage 1: raw fields beside the read data
    logic [12:0] r1_raw;
    logic [11:0] r1_tdc;
    logic [9:0]  r1_id;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_raw <= in_raw;
            r1_tdc <= in_tdc;
            r1_id  <= id_n;
        end
    end

    // stage 2: pedestal subtraction and slope product
    logic signed [33:0] adc_n;
    logic signed [44:0] prod_n;
    assign adc_n  = $signed({5'b0, r1_raw, 16'b0}) - 34'(signed'(r1_row[htwc_pkg::SEL_PEDESTAL]));
    assign prod_n = 45'(signed'(r1_row[htwc_pkg::SEL_SLOPE]) * $signed({1'b0, r1_tdc}));

    logic signed [33:0] r2_adc;
    logic signed [44:0] r2_prod;
    htwc_pkg::t_row     r2_row;
    logic signed [31:0] r2_sd;
    logic [11:0]        r2_tdc;
    logic [9:0]         r2_id;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_adc  <= adc_n;
            r2_prod <= prod_n;
            r2_row  <= r1_row;
            r2_sd   <= r1_sd;
            r2_tdc  <= r1_tdc;
            r2_id   <= r1_id;
        end
    end

    // stage 3: time sum, walk clamp, divisor
    logic signed [T_W-1:0] t_n;
    logic signed [D_W-1:0] x_n, d_n, amax, thr;
    logic                  use_walk_n, inwin_n;
    logic signed [31:0]    adc_sat_n;

    always_comb begin
        t_n = -T_W'(r_global_offset) - T_W'(r2_sd)
            + T_W'(signed'(r2_row[htwc_pkg::SEL_PADDLE_DELAY]))
            + T_W'(signed'(r2_row[htwc_pkg::SEL_T0])) - T_W'(r2_prod);
        amax = D_W'(signed'(r2_row[htwc_pkg::SEL_ADC_MAX]));
        thr  = $signed({6'b0, r_walk_thr, 16'b0});
        use_walk_n = 1'b1;
        if (D_W'(r2_adc) > amax) begin
            x_n = amax;
        end else if (D_W'(r2_adc) > thr) begin
            x_n = D_W'(r2_adc);
        end else if (r2_adc > 34'sd0) begin
            x_n = thr;
        end else begin
            x_n = '0;
            use_walk_n = 1'b0;
        end
        d_n = x_n - D_W'(signed'(r2_row[htwc_pkg::SEL_W2]));
        inwin_n = !r2_adc[33] && r2_tdc >= r_win_low && r2_tdc <= r_win_high;
        if (r2_adc > 34'sh0_7FFF_FFFF) begin
            adc_sat_n = 32'sh7FFF_FFFF;
        end else if (r2_adc < -34'sh0_8000_0000) begin
            adc_sat_n = 32'sh8000_0000;
        end else begin
            adc_sat_n = r2_adc[31:0];
        end
    end

    logic signed [T_W-1:0] r3_t;
    logic signed [31:0]    r3_w0, r3_w1, r3_adc_sat;
    logic signed [D_W-1:0] r3_d;
    logic                  r3_use_walk, r3_inwin;
    logic [9:0]            r3_id;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_t        <= t_n;
            r3_w0       <= r2_row[htwc_pkg::SEL_W0];
            r3_w1       <= r2_row[htwc_pkg::SEL_W1];
            r3_d        <= d_n;
            r3_use_walk <= use_walk_n;
            r3_inwin    <= inwin_n;
            r3_adc_sat  <= adc_sat_n;
            r3_id       <= r2_id;
        end
    end

    // stage 4: operand magnitudes and signs
    htwc_pkg::t_ctx  ctx_n;
    logic [NS-1:0]   nabs_n;
    logic [D_W-1:0]  dabs_n;
    logic [31:0]     w1abs;

    always_comb begin
        w1abs  = r3_w1[31] ? 32'(-r3_w1) : r3_w1;
        nabs_n = {w1abs, 16'b0};
        dabs_n = r3_d[D_W-1] ? D_W'(-r3_d) : r3_d;
        ctx_n.t        = r3_t;
        ctx_n.w0       = r3_w0;
        ctx_n.use_walk = r3_use_walk;
        ctx_n.divz     = r3_use_walk && r3_d == '0;
        ctx_n.w1_pos   = !r3_w1[31] && r3_w1 != '0;
        ctx_n.w1_neg   = r3_w1[31];
        ctx_n.q_neg    = r3_w1[31] ^ r3_d[D_W-1];
        ctx_n.inwin    = r3_inwin;
        ctx_n.adc_sat  = r3_adc_sat;
        ctx_n.id       = r3_id;
    end

    htwc_pkg::t_ctx r4_ctx;
    logic [NS-1:0]  r4_nabs;
    logic [D_W-1:0] r4_dabs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ctx  <= ctx_n;
            r4_nabs <= nabs_n;
            r4_dabs <= dabs_n;
        end
    end

    // restoring divider, one quotient bit per stage; the numerator shifts out
    // of the top of nq while quotient bits shift in at the bottom
    htwc_pkg::t_ctx r_dctx [NS];
    logic [D_W-1:0] r_dden [NS];
    logic [D_W-1:0] r_drem [NS];
    logic [NS-1:0]  r_dnq  [NS];
    logic [D_W-1:0] n_drem [NS];
    logic [NS-1:0]  n_dnq  [NS];

    always_comb begin
        logic [D_W:0]   sh;
        logic [D_W-1:0] den, rem;
        logic [NS-1:0]  nq;
        for (int k = 0; k < NS; k++) begin
            den = (k == 0) ? r4_dabs : r_dden[k-1];
            rem = (k == 0) ? '0      : r_drem[k-1];
            nq  = (k == 0) ? r4_nabs : r_dnq[k-1];
            sh  = {rem, nq[NS-1]};
            if (sh >= {1'b0, den}) begin
                n_drem[k] = D_W'(sh - {1'b0, den});
                n_dnq[k]  = {nq[NS-2:0], 1'b1};
            end else begin
                n_drem[k] = sh[D_W-1:0];
                n_dnq[k]  = {nq[NS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                r_dctx[k] <= (k == 0) ? r4_ctx  : r_dctx[k-1];
                r_dden[k] <= (k == 0) ? r4_dabs : r_dden[k-1];
                r_drem[k] <= n_drem[k];
                r_dnq[k]  <= n_dnq[k];
            end
        end
    end

    // final sum and saturation
    htwc_pkg::t_ctx     fctx;
    logic signed [NS:0] q;
    logic signed [SUM_W-1:0] sum_tw, sum_all;
    htwc_pkg::t_result  res_n, r_res;

    always_comb begin
        fctx    = r_dctx[NS-1];
        q       = fctx.q_neg ? -$signed({1'b0, r_dnq[NS-1]}) : $signed({1'b0, r_dnq[NS-1]});
        sum_tw  = SUM_W'(fctx.t) + SUM_W'(fctx.w0);
        sum_all = sum_tw + SUM_W'(q);
        if (!fctx.use_walk) begin
            res_n.ht = htwc_pkg::sat48(SUM_W'(fctx.t));
        end else if (fctx.divz) begin
            if (fctx.w1_pos) begin
                res_n.ht = htwc_pkg::HT_MAX;
            end else if (fctx.w1_neg) begin
                res_n.ht = htwc_pkg::HT_MIN;
            end else begin
                res_n.ht = htwc_pkg::sat48(sum_tw);
            end
        end else begin
            res_n.ht = htwc_pkg::sat48(sum_all);
        end
        res_n.adc   = fctx.adc_sat;
        res_n.inwin = fctx.inwin;
        res_n.id    = fctx.id;
        res_n.divz  = fctx.divz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= res_n;
        end
    end

    assign m_axis_tdata = {4'b0, r_res};

    `HTWC_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
    `HTWC_ASSERT_NEXT(a_no_result_for_write, acc && in_op == htwc_pkg::OP_WRITE, !r_v1, "write transaction entered hit pipeline")
    `HTWC_ASSERT_NEXT(a_no_result_bad_channel, acc && !ch_ok, !r_v1, "out of range channel entered hit pipeline")
    `HTWC_ASSERT_NEXT(a_divider_drains, r_dv[NS-1] && en, m_axis_tvalid, "divider result lost before output")

endmodule

/* tb/hit_time_walk_calibration_unit_tb.sv */
`timescale 1ns / 1ps

module hit_time_walk_calibration_unit_tb;

    localparam int  NUM_CH    = 24;
    localparam int  NUM_SEC   = 6;
    localparam int  SEGS      = 4;
    localparam int  DRAIN_CYC = 70;
    localparam int  LIMIT     = 600000;
    localparam int  PHASE_N   = 250;
    localparam longint HT_HI  = 64'sd140737488355327;
    localparam longint HT_LO  = -64'sd140737488355328;
    localparam longint ONE    = 64'sd65536;

    class hit_scoreboard;
        longint chan_tbl[htwc_pkg::NUM_CH_TABLES][NUM_CH];
        longint sector_dly[NUM_SEC];
        longint offset;
        int unsigned win_lo, win_hi, walk_thr;
        htwc_pkg::t_result hit_results_q[$];
        int errors;
        int hits_checked;
        int divz_seen;

        function new();
            offset   = 0;
            win_lo   = 0;
            win_hi   = 4095;
            walk_thr = 50;
            errors   = 0;
            hits_checked = 0;
            divz_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                htwc_pkg::CFG_GLOBAL_OFFSET:  offset   = longint'($signed(val));
                htwc_pkg::CFG_TDC_WIN_LOW:    win_lo   = val[11:0];
                htwc_pkg::CFG_TDC_WIN_HIGH:   win_hi   = val[11:0];
                htwc_pkg::CFG_WALK_THRESHOLD: walk_thr = val[12:0];
                default: ;
            endcase
        endfunction

        // accepted input transaction: update the tables or predict the hit
        function void note_input(logic op, logic [4:0] ch, logic [12:0] raw,
                                 logic [11:0] tdc, logic [3:0] sel,
                                 logic signed [31:0] word);
            longint adc, t, x, d, q, ht, thr, amax, w0, w1, w2;
            bit walk;
            int sec, seg;
            htwc_pkg::t_result r;
            if (op == htwc_pkg::OP_WRITE) begin
                if (sel < htwc_pkg::NUM_CH_TABLES) begin
                    if (ch < NUM_CH) chan_tbl[sel][ch] = longint'(word);
                end else if (sel == htwc_pkg::SEL_SECTOR_DELAY) begin
                    if (ch < NUM_SEC) sector_dly[ch] = longint'(word);
                end
                return;
            end
            if (ch >= NUM_CH) return;
            sec  = ch / SEGS;
            seg  = ch % SEGS;
            adc  = longint'(raw) * ONE - chan_tbl[htwc_pkg::SEL_PEDESTAL][ch];
            t    = -offset - sector_dly[sec] + chan_tbl[htwc_pkg::SEL_PADDLE_DELAY][ch]
                   + chan_tbl[htwc_pkg::SEL_T0][ch]
                   - chan_tbl[htwc_pkg::SEL_SLOPE][ch] * longint'(tdc);
            amax = chan_tbl[htwc_pkg::SEL_ADC_MAX][ch];
            w0   = chan_tbl[htwc_pkg::SEL_W0][ch];
            w1   = chan_tbl[htwc_pkg::SEL_W1][ch];
            w2   = chan_tbl[htwc_pkg::SEL_W2][ch];
            thr  = longint'(walk_thr) * ONE;
            walk = 1;
            x    = 0;
            if (adc > amax) x = amax;
            else if (adc > thr) x = adc;
            else if (adc > 0) x = thr;
            else walk = 0;
            r.divz = 1'b0;
            if (walk) begin
                d = x - w2;
                if (d == 0) begin
                    r.divz = 1'b1;
                    if (w1 > 0) ht = HT_HI;
                    else if (w1 < 0) ht = HT_LO;
                    else ht = t + w0;
                end else begin
                    q  = (w1 * ONE) / d;
                    ht = t + w0 + q;
                end
            end else begin
                ht = t;
            end
            if (ht > HT_HI) ht = HT_HI;
            if (ht < HT_LO) ht = HT_LO;
            r.ht    = ht[47:0];
            r.inwin = (adc >= 0 && tdc >= win_lo && tdc <= win_hi);
            r.id    = 10'((sec + 1) * 100 + (seg + 1) * 10);
            if (adc > 64'sd2147483647) adc = 64'sd2147483647;
            if (adc < -64'sd2147483648) adc = -64'sd2147483648;
            r.adc   = adc[31:0];
            hit_results_q.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        endtask

        task check_result(logic [95:0] d);
            htwc_pkg::t_result e;
            if (hit_results_q.size() == 0) begin
                report("unexpected result", 64'(d[63:0]), 64'd0);
                return;
            end
            e = hit_results_q.pop_front();
            hits_checked++;
            if (e.divz) divz_seen++;
            if (d[31:0]  !== e.adc)   report("adc_calibrated", 64'(d[31:0]), 64'(e.adc));
            if (d[79:32] !== e.ht)    report("hit_time", 64'(d[79:32]), 64'(e.ht));
            if (d[80]    !== e.inwin) report("in_window", 64'(d[80]), 64'(e.inwin));
            if (d[90:81] !== e.id)    report("id_digits", 64'(d[90:81]), 64'(e.id));
            if (d[91]    !== e.divz)  report("walk_div_zero", 64'(d[91]), 64'(e.divz));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [4:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;

    hit_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    int items_sent = 0;

    hit_time_walk_calibration_unit u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** hit_time_walk_calibration_unit: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

    task send_item(logic op, logic [4:0] ch, logic [12:0] raw, logic [11:0] tdc,
                   logic [3:0] sel, logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, word, tdc, raw, ch};
        s_axis_tuser  = {sel, op};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, ch, raw, tdc, sel, word);
        items_sent++;
        @(negedge i_clk);
    endtask

    task hit(logic [4:0] ch, logic [12:0] raw, logic [11:0] tdc);
        send_item(htwc_pkg::OP_HIT, ch, raw, tdc, 4'($urandom_range(0, 15)), $urandom);
    endtask

    task write_cal(logic [3:0] sel, logic [4:0] ch, logic [31:0] word);
        send_item(htwc_pkg::OP_WRITE, ch, 13'($urandom), 12'($urandom), sel, word);
    endtask

    // block idle: all hits out and the pipeline empty of writes
    task drain();
        s_axis_tvalid = 1'b0;
        while (sb.hit_results_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [31:0] gen_cal(logic [3:0] sel);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        case (sel)
            htwc_pkg::SEL_PEDESTAL:
                return ($urandom_range(0, 300) << 16) | $urandom_range(0, 65535);
            htwc_pkg::SEL_ADC_MAX:
                return ($urandom_range(100, 8191) << 16) | $urandom_range(0, 65535);
            htwc_pkg::SEL_W2:    return $urandom_range(0, 80) << 16;
            htwc_pkg::SEL_SLOPE: return $urandom_range(0, 4 << 16);
            default:             return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    task random_item();
        int r;
        logic [4:0] ch;
        r  = $urandom_range(0, 99);
        ch = 5'($urandom_range(0, NUM_CH - 1));
        if (r < 70) begin
            hit(ch, 13'($urandom), 12'($urandom));
        end else if (r < 82) begin
            logic [3:0] sel;
            sel = 4'($urandom_range(0, 8));
            if (sel == htwc_pkg::SEL_SECTOR_DELAY) ch = 5'($urandom_range(0, NUM_SEC - 1));
            write_cal(sel, ch, gen_cal(sel));
        end else if (r < 87) begin
            // divisor forced to zero: w2 equals the clamp value
            write_cal(htwc_pkg::SEL_W2, ch, 32'(sb.chan_tbl[htwc_pkg::SEL_ADC_MAX][ch]));
            hit(ch, 13'd8191, 12'($urandom));
        end else if (r < 91) begin
            write_cal(htwc_pkg::SEL_W2, ch, sb.walk_thr << 16);
            hit(ch, 13'($urandom_range(0, 60)), 12'($urandom));
        end else if (r < 95) begin
            hit(5'($urandom_range(NUM_CH, 31)), 13'($urandom), 12'($urandom));
        end else if (r < 97) begin
            write_cal(4'($urandom_range(9, 15)), 5'($urandom), $urandom);
        end else if (r < 99) begin
            write_cal(4'($urandom_range(0, 7)), 5'($urandom_range(NUM_CH, 31)), $urandom);
        end else begin
            write_cal(htwc_pkg::SEL_SECTOR_DELAY, 5'($urandom_range(NUM_SEC, 31)), $urandom);
        end
    endtask

    initial begin
        int n;
        bit paused;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill every table entry before any hit reads it
        for (int c = 0; c < NUM_CH; c++)
            for (int s = 0; s < htwc_pkg::NUM_CH_TABLES; s++)
                write_cal(4'(s), 5'(c), gen_cal(4'(s)));
        for (int c = 0; c < NUM_SEC; c++)
            write_cal(htwc_pkg::SEL_SECTOR_DELAY, 5'(c), gen_cal(htwc_pkg::SEL_SECTOR_DELAY));

        // directed: clamp regions, zero divisor, saturation, edges
        write_cal(htwc_pkg::SEL_PEDESTAL, 5'd1, 32'd20 << 16);
        write_cal(htwc_pkg::SEL_ADC_MAX, 5'd1, 32'd500 << 16);
        write_cal(htwc_pkg::SEL_W2, 5'd1, 32'd10 << 16);
        hit(5'd1, 13'd8191, 12'd0);
        hit(5'd1, 13'd300, 12'd4095);
        hit(5'd1, 13'd30, 12'd100);
        hit(5'd1, 13'd0, 12'd100);
        write_cal(htwc_pkg::SEL_ADC_MAX, 5'd2, 32'd400 << 16);
        write_cal(htwc_pkg::SEL_W2, 5'd2, 32'd400 << 16);
        write_cal(htwc_pkg::SEL_W1, 5'd2, 32'h7FFF_FFFF);
        hit(5'd2, 13'd8191, 12'd7);
        write_cal(htwc_pkg::SEL_W1, 5'd2, 32'h8000_0000);
        hit(5'd2, 13'd8191, 12'd7);
        write_cal(htwc_pkg::SEL_W1, 5'd2, 32'd0);
        hit(5'd2, 13'd8191, 12'd7);
        write_cal(htwc_pkg::SEL_PEDESTAL, 5'd3, 32'h8000_0000);
        hit(5'd3, 13'd8191, 12'd4095);
        write_cal(htwc_pkg::SEL_PEDESTAL, 5'd3, 32'h7FFF_FFFF);
        hit(5'd3, 13'd0, 12'd0);
        hit(5'd23, 13'd100, 12'd50);
        hit(5'd31, 13'd100, 12'd50);
        write_cal(htwc_pkg::SEL_SECTOR_DELAY, 5'd7, $urandom);
        write_cal(4'd15, 5'd0, $urandom);
        write_cal(htwc_pkg::SEL_PEDESTAL, 5'd3, 32'd5 << 16);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(htwc_pkg::CFG_GLOBAL_OFFSET, 32'd0);
                    write_reg(htwc_pkg::CFG_TDC_WIN_LOW, 32'd0);
                    write_reg(htwc_pkg::CFG_TDC_WIN_HIGH, 32'd4095);
                    write_reg(htwc_pkg::CFG_WALK_THRESHOLD, 32'd50);
                end
                1: begin
                    write_reg(htwc_pkg::CFG_GLOBAL_OFFSET, 32'h7FFF_FFFF);
                    write_reg(htwc_pkg::CFG_TDC_WIN_LOW, 32'd100);
                    write_reg(htwc_pkg::CFG_TDC_WIN_HIGH, 32'd100);
                    write_reg(htwc_pkg::CFG_WALK_THRESHOLD, 32'd0);
                end
                2: begin
                    write_reg(htwc_pkg::CFG_GLOBAL_OFFSET, 32'h8000_0000);
                    write_reg(htwc_pkg::CFG_TDC_WIN_LOW, 32'd4095);
                    write_reg(htwc_pkg::CFG_TDC_WIN_HIGH, 32'd0);
                    write_reg(htwc_pkg::CFG_WALK_THRESHOLD, 32'd8191);
                end
                3: begin
                    write_reg(htwc_pkg::CFG_GLOBAL_OFFSET, $urandom);
                    write_reg(htwc_pkg::CFG_TDC_WIN_LOW, 32'd4095);
                    write_reg(htwc_pkg::CFG_TDC_WIN_HIGH, 32'd4095);
                    write_reg(htwc_pkg::CFG_WALK_THRESHOLD, 32'($urandom_range(0, 300)));
                end
                4: begin
                    write_reg(htwc_pkg::CFG_GLOBAL_OFFSET, $urandom);
                    write_reg(htwc_pkg::CFG_TDC_WIN_LOW, 32'($urandom_range(0, 2000)));
                    write_reg(htwc_pkg::CFG_TDC_WIN_HIGH, 32'($urandom_range(2000, 4095)));
                    write_reg(htwc_pkg::CFG_WALK_THRESHOLD, 32'($urandom_range(0, 8191)));
                end
                default: begin
                    write_reg(htwc_pkg::CFG_GLOBAL_OFFSET, 32'd0);
                    write_reg(htwc_pkg::CFG_TDC_WIN_LOW, 32'd1000);
                    write_reg(htwc_pkg::CFG_TDC_WIN_HIGH, 32'd3000);
                    write_reg(htwc_pkg::CFG_WALK_THRESHOLD, 32'd50);
                end
            endcase
            if (ph < 2) begin
                send_idle_pct = 37; recv_stall_pct = 58;
            end else if (ph < 4) begin
                send_idle_pct = 58; recv_stall_pct = 37;
            end else begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
            n = items_sent;
            paused = 1'b0;
            while (items_sent - n < PHASE_N) begin
                random_item();
                // once, halfway through phase 1, the sender holds off until all hits are out
                if (!paused && items_sent - n >= PHASE_N / 2 && ph == 1) begin
                    paused = 1'b1;
                    s_axis_tvalid = 1'b0;
                    while (sb.hit_results_q.size() != 0) @(negedge i_clk);
                end
            end
        end

        drain();
        $display("%0d transactions sent, %0d hits checked (%0d with zero walk divisor)",
                 items_sent, sb.hits_checked, sb.divz_seen);
        $display("six register settings, sender and receiver back-pressure in both mixes");
        if (sb.errors == 0 && sb.hit_results_q.size() == 0) begin
            $display("** hit_time_walk_calibration_unit: PASSED **");
        end else begin
            $display("** hit_time_walk_calibration_unit: FAILED **");
        end
        $finish;
    end

endmodule
